>>> rtl/srep_pkg.sv
package srep_pkg;

  localparam int MAX_PATTERN     = 16;
  localparam int MAX_REPLACEMENT = 16;
  localparam int SEQ_DEPTH       = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                  : MAX_REPLACEMENT;
  localparam int LEN_W           = $clog2(SEQ_DEPTH + 1);
  localparam int IDX_W           = $clog2(SEQ_DEPTH);
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW        = 3'd0,
    REG_PATTERN_HIGH       = 3'd1,
    REG_PATTERN_LENGTH     = 3'd2,
    REG_REPLACEMENT_LOW    = 3'd3,
    REG_REPLACEMENT_HIGH   = 3'd4,
    REG_REPLACEMENT_LENGTH = 3'd5
  } cfg_reg_t;

  // at most one command per input item: a run of bytes to emit and the end mark
  typedef struct packed {
    logic [SEQ_DEPTH-1:0][7:0] bytes;
    logic [LEN_W-1:0]          count;
    logic                      last;
  } cmd_t;

endpackage

>>> rtl/srep_if.sv
interface srep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_content;

  modport source (output valid, output data_byte, output end_of_content, input ready);
  modport sink (input valid, input data_byte, input end_of_content, output ready);
endinterface

interface srep_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_of_content;

  modport source (output valid, output out_byte, output byte_valid,
                  output last_of_content, input ready);
  modport sink (input valid, input out_byte, input byte_valid,
                input last_of_content, output ready);
endinterface

>>> rtl/srep_front.sv
module srep_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [srep_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srep_pkg::CFG_DATA_W-1:0]   cfg_data,
  srep_in_if.sink                           in_stream,
  input  logic                              push_ready,
  output logic                              push,
  output srep_pkg::cmd_t                    push_cmd
);

  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [srep_pkg::LEN_W-1:0] pattern_length;
  logic [63:0] replacement_low;
  logic [63:0] replacement_high;
  logic [srep_pkg::LEN_W-1:0] replacement_length;

  logic [srep_pkg::MAX_PATTERN-1:0][7:0] window;
  logic [srep_pkg::MAX_PATTERN-1:0][7:0] window_next;
  logic [srep_pkg::LEN_W-1:0] window_count;
  logic [srep_pkg::LEN_W-1:0] window_count_next;

  logic [15:0][7:0] pat_bytes;
  logic [15:0][7:0] rep_bytes;
  logic [srep_pkg::LEN_W-1:0] plen;
  logic [srep_pkg::LEN_W-1:0] rlen;
  logic accept;

  assign pat_bytes = {pattern_high, pattern_low};
  assign rep_bytes = {replacement_high, replacement_low};

  // lengths above the supported maximum saturate
  assign plen = (pattern_length > srep_pkg::LEN_W'(srep_pkg::MAX_PATTERN))
              ? srep_pkg::LEN_W'(srep_pkg::MAX_PATTERN) : pattern_length;
  assign rlen = (replacement_length > srep_pkg::LEN_W'(srep_pkg::MAX_REPLACEMENT))
              ? srep_pkg::LEN_W'(srep_pkg::MAX_REPLACEMENT) : replacement_length;

  assign in_stream.ready = push_ready;
  assign accept = in_stream.valid && push_ready;

  always_comb begin
    logic [srep_pkg::MAX_PATTERN-1:0][7:0] win_new;
    logic [srep_pkg::LEN_W-1:0] base;
    logic [srep_pkg::LEN_W-1:0] cnt_new;
    logic full;
    logic match;
    logic [srep_pkg::LEN_W-1:0] emit_count;

    win_new = window;
    base = (window_count >= plen) ? '0 : window_count;
    if (plen == '0) begin
      base = '0;
    end
    win_new[base[srep_pkg::IDX_W-1:0]] = in_stream.data_byte;
    cnt_new = base + srep_pkg::LEN_W'(1);
    full = (plen == '0) || (cnt_new == plen);

    match = (plen != '0) && full;
    for (int i = 0; i < srep_pkg::MAX_PATTERN; i++) begin
      if ((srep_pkg::LEN_W'(i) < plen) && (win_new[i] != pat_bytes[i])) begin
        match = 1'b0;
      end
    end

    window_next = win_new;
    window_count_next = window_count;
    emit_count = '0;
    push_cmd.bytes = '0;
    push_cmd.bytes[srep_pkg::MAX_PATTERN-1:0] = win_new;

    if (plen == '0) begin
      emit_count = srep_pkg::LEN_W'(1);
      window_count_next = '0;
    end else if (match) begin
      push_cmd.bytes = '0;
      for (int i = 0; i < srep_pkg::MAX_REPLACEMENT; i++) begin
        push_cmd.bytes[i] = rep_bytes[i];
      end
      emit_count = rlen;
      window_count_next = '0;
    end else if (full) begin
      // oldest byte leaves, the rest moves down one place
      emit_count = in_stream.end_of_content ? cnt_new : srep_pkg::LEN_W'(1);
      for (int i = 0; i < srep_pkg::MAX_PATTERN - 1; i++) begin
        window_next[i] = win_new[i+1];
      end
      window_count_next = plen - srep_pkg::LEN_W'(1);
    end else begin
      emit_count = in_stream.end_of_content ? cnt_new : '0;
      window_count_next = cnt_new;
    end

    if (in_stream.end_of_content) begin
      window_count_next = '0;
    end

    push_cmd.count = emit_count;
    push_cmd.last = in_stream.end_of_content;
    push = accept && ((emit_count != '0) || in_stream.end_of_content);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low        <= '0;
      pattern_high       <= '0;
      pattern_length     <= '0;
      replacement_low    <= '0;
      replacement_high   <= '0;
      replacement_length <= '0;
      window_count       <= '0;
    end else if (cfg_we) begin
      case (srep_pkg::cfg_reg_t'(cfg_index))
        srep_pkg::REG_PATTERN_LOW:        pattern_low <= cfg_data;
        srep_pkg::REG_PATTERN_HIGH:       pattern_high <= cfg_data;
        srep_pkg::REG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[srep_pkg::LEN_W-1:0];
          window_count   <= '0;
        end
        srep_pkg::REG_REPLACEMENT_LOW:    replacement_low <= cfg_data;
        srep_pkg::REG_REPLACEMENT_HIGH:   replacement_high <= cfg_data;
        srep_pkg::REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[srep_pkg::LEN_W-1:0];
        default: ;
      endcase
    end else if (accept) begin
      window_count <= window_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

>>> rtl/srep_queue.sv
module srep_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  srep_pkg::cmd_t push_cmd,
  output logic           push_ready,
  input  logic           pop,
  output logic           head_valid,
  output srep_pkg::cmd_t head
);

  srep_pkg::cmd_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign push_ready = (fill != 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (!push && pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

>>> rtl/srep_back.sv
module srep_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  srep_pkg::cmd_t head,
  output logic           pop,
  srep_out_if.source     out_stream
);

  logic                       out_valid;
  logic [7:0]                 out_byte;
  logic                       byte_valid;
  logic                       last_of_content;
  logic [srep_pkg::IDX_W-1:0] idx;

  logic load;
  logic emit;
  logic is_marker;
  logic final_byte;

  assign out_stream.valid           = out_valid;
  assign out_stream.out_byte        = out_byte;
  assign out_stream.byte_valid      = byte_valid;
  assign out_stream.last_of_content = last_of_content;

  assign load = !out_valid || out_stream.ready;
  assign emit = head_valid && load;
  // a command with no bytes is the empty end marker
  assign is_marker = (head.count == '0);
  assign final_byte = is_marker ||
                      ({1'b0, idx} == (head.count - srep_pkg::LEN_W'(1)));
  assign pop = emit && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (emit) begin
      out_valid <= 1'b1;
      idx       <= final_byte ? '0 : idx + srep_pkg::IDX_W'(1);
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte        <= is_marker ? 8'd0 : head.bytes[idx];
      byte_valid      <= !is_marker;
      last_of_content <= head.last && final_byte;
    end
  end

endmodule

>>> rtl/stream_pattern_replace_core.sv
// first result of a transaction is registered in the command queue, then in the output register, before it is offered
// throughput: one output byte per cycle while out_stream.ready is high; an input item that yields k
// results gives them as consecutive output bytes (replacement length, or up to 16 on a flush)
// input takes one item per cycle while the two-entry command queue has room
// reset: synchronous active-high rst clears config registers, lengths, window count, queue and output valid
module stream_pattern_replace_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [srep_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srep_pkg::CFG_DATA_W-1:0] cfg_data,
  srep_in_if.sink                         in_stream,
  srep_out_if.source                      out_stream
);

  logic           push;
  logic           push_ready;
  srep_pkg::cmd_t push_cmd;
  logic           pop;
  logic           head_valid;
  srep_pkg::cmd_t head;

  srep_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_stream  (in_stream),
    .push_ready (push_ready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  srep_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  srep_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_stream (out_stream)
  );

endmodule
